// ----- hw/rtl/pekm_pkg.sv -----
// ----------------------------------------------------------------------------
// pekm_pkg
// Shared widths, command codes, register indexes and reset values of the path
// keepalive monitor.
// ----------------------------------------------------------------------------
package pekm_pkg;

   // Transaction field widths
   localparam int CMD_W     = 2;
   localparam int PATH_W    = 6;
   localparam int NOW_W     = 32;
   localparam int RETRY_W   = 4;
   localparam int COUNT_W   = 32;

   // Register widths
   localparam int T3_W      = 20;
   localparam int ECHO_W    = 22;
   localparam int N3_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;

   // Commands
   localparam logic [CMD_W-1:0] CMD_CHECK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEND     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_T3   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_N3   = 2'd2;

   // Register reset values
   localparam logic [T3_W-1:0]   T3_RESET   = 20'd3000;
   localparam logic [ECHO_W-1:0] ECHO_RESET = 22'd60000;
   localparam logic [N3_W-1:0]   N3_RESET   = 4'd5;

   // Retry count saturates here
   localparam logic [RETRY_W-1:0] RETRY_MAX = 4'd15;

endpackage

// ----- hw/rtl/pekm_req_if.sv -----
// ----------------------------------------------------------------------------
// pekm_req_if
// Command channel: path index, current time and command per transaction.
// ----------------------------------------------------------------------------
interface pekm_req_if;
   logic                          valid;
   logic                          ready;
   logic [pekm_pkg::CMD_W-1:0]    cmd;
   logic [pekm_pkg::PATH_W-1:0]   path_index;
   logic [pekm_pkg::NOW_W-1:0]    now_ms;

   modport source (output valid, output cmd, output path_index, output now_ms,
                   input ready);
   modport sink   (input valid, input cmd, input path_index, input now_ms,
                   output ready);
endinterface

// ----- hw/rtl/pekm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pekm_rsp_if
// Result channel: flags and path status after each command.
// ----------------------------------------------------------------------------
interface pekm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           send_echo;
   logic                           error_notify;
   logic                           path_in_error;
   logic                           echo_pending;
   logic [pekm_pkg::RETRY_W-1:0]   retry_count;
   logic [pekm_pkg::COUNT_W-1:0]   echo_sent_count;
   logic [pekm_pkg::COUNT_W-1:0]   retransmit_count;

   modport source (output valid, output send_echo, output error_notify,
                   output path_in_error, output echo_pending, output retry_count,
                   output echo_sent_count, output retransmit_count,
                   input ready);
   modport sink   (input valid, input send_echo, input error_notify,
                   input path_in_error, input echo_pending, input retry_count,
                   input echo_sent_count, input retransmit_count,
                   output ready);
endinterface

// ----- hw/rtl/path_echo_keepalive_monitor.sv -----
// ----------------------------------------------------------------------------
// path_echo_keepalive_monitor - echo keepalive supervision over a path table
// A command is registered in stage 1 (table read), then its update in the
// result register. Synchronous reset: no startup pass.
// Throughput: one transaction per cycle, any path order, while results are
// taken; a hit on the path that stage 1 is writing back is forwarded.
// ----------------------------------------------------------------------------
module path_echo_keepalive_monitor #(
   parameter int NUM_PATHS = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   pekm_req_if.sink                            req_chan,
   pekm_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [pekm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pekm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Only 2^PATH_W paths are addressable, so the table never grows past that.
   localparam int MAX_PATHS = 1 << pekm_pkg::PATH_W;
   localparam int USED      = (NUM_PATHS < MAX_PATHS) ? NUM_PATHS : MAX_PATHS;
   localparam int ADDR_W    = (USED > 1) ? $clog2(USED) : 1;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   // Compare width wide enough for elapsed time and either timeout register.
   localparam int CMP_W     = (TIME_BITS > pekm_pkg::ECHO_W) ? TIME_BITS
                                                               : pekm_pkg::ECHO_W;

   typedef struct packed {
      logic [TIME_BITS-1:0]          send_time;
      logic [TIME_BITS-1:0]          recv_time;
      logic [pekm_pkg::RETRY_W-1:0]  retries;
      logic                          pending;
      logic                          error;
      logic [pekm_pkg::COUNT_W-1:0]  sent;
      logic [pekm_pkg::COUNT_W-1:0]  rtx;
   } entry_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [pekm_pkg::T3_W-1:0]   t3_ff;
   logic [pekm_pkg::ECHO_W-1:0] echo_ff;
   logic [pekm_pkg::N3_W-1:0]   n3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_ff   <= pekm_pkg::T3_RESET;
         echo_ff <= pekm_pkg::ECHO_RESET;
         n3_ff   <= pekm_pkg::N3_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pekm_pkg::CSR_T3:   t3_ff   <= csr_write_data[pekm_pkg::T3_W-1:0];
            pekm_pkg::CSR_ECHO: echo_ff <= csr_write_data[pekm_pkg::ECHO_W-1:0];
            pekm_pkg::CSR_N3:   n3_ff   <= csr_write_data[pekm_pkg::N3_W-1:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake
   // Stage 1 holds the transaction whose table entry was just read; the
   // result register parts it from the consumer.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff;
   logic s1_adv;
   logic req_fire;

   assign s1_adv         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // ------------------------------------------------------------------
   // Stage 1 registers and table read
   // ------------------------------------------------------------------
   logic [pekm_pkg::CMD_W-1:0] s1_cmd_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic                       s1_in_range_ff;
   logic [TIME_BITS-1:0]       s1_now_ff;
   entry_type                  rd_data_ff;
   logic                       rd_vld_ff;
   entry_type                  fwd_ff;
   logic                       s1_fwd_ff;

   entry_type                  path_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]       entry_vld_ff;

   logic [ADDR_W-1:0]          rd_addr;
   logic                       rd_in_range;
   logic                       fwd_hit;
   entry_type                  nxt;
   logic                       wr_en;

   assign rd_addr     = ADDR_W'(req_chan.path_index);
   assign rd_in_range = 32'(req_chan.path_index) < 32'(NUM_PATHS);
   // Previous transaction writes this same entry at this edge: take its value.
   assign fwd_hit     = s1_valid_ff && s1_in_range_ff && (rd_addr == s1_addr_ff);
   assign wr_en       = s1_valid_ff && s1_adv && s1_in_range_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         entry_vld_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (wr_en) begin
            entry_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff      <= req_chan.cmd;
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= rd_in_range;
         s1_now_ff      <= TIME_BITS'(req_chan.now_ms);
         rd_data_ff     <= path_mem[rd_addr];
         rd_vld_ff      <= entry_vld_ff[rd_addr];
         fwd_ff         <= nxt;
         s1_fwd_ff      <= fwd_hit;
      end
      if (wr_en) begin
         path_mem[s1_addr_ff] <= nxt;
      end
   end

   // ------------------------------------------------------------------
   // Entry update
   // ------------------------------------------------------------------
   entry_type cur;
   logic      send_flag, notify_flag, err_flag;

   always_comb begin
      logic [TIME_BITS-1:0]         since_send;
      logic [TIME_BITS-1:0]         gap;
      logic                         t3_ok;
      logic                         iv_ok;
      logic                         stale;
      logic [pekm_pkg::RETRY_W-1:0] r1;
      logic                         p1;

      cur = s1_fwd_ff ? fwd_ff : (rd_vld_ff ? rd_data_ff : '0);
      nxt = cur;
      send_flag   = 1'b0;
      notify_flag = 1'b0;
      err_flag    = 1'b0;

      since_send = s1_now_ff - cur.send_time;
      gap        = cur.send_time - cur.recv_time;
      t3_ok      = CMP_W'(since_send) >= CMP_W'(t3_ff);
      iv_ok      = CMP_W'(since_send) >= CMP_W'(echo_ff);
      // No response since the last send: gap nonzero and in the forward half.
      stale      = (gap != '0) && !gap[TIME_BITS-1];
      r1         = cur.retries;
      p1         = cur.pending;

      case (s1_cmd_ff)
         pekm_pkg::CMD_CHECK: begin
            if ((cur.retries >= n3_ff) && t3_ok) begin
               // retries exhausted: path in error, nothing else moves
               nxt.error   = 1'b1;
               notify_flag = !cur.error;
               err_flag    = 1'b1;
            end else begin
               if (stale && t3_ok && (cur.retries == '0)) begin
                  r1      = pekm_pkg::RETRY_W'(1);
                  p1      = 1'b1;
                  nxt.rtx = cur.rtx + pekm_pkg::COUNT_W'(1);
               end
               nxt.retries = r1;
               nxt.pending = p1;
               if (((r1 != '0) && t3_ok) || ((r1 == '0) && iv_ok)) begin
                  if (!p1 && (r1 != '0) && (r1 < pekm_pkg::RETRY_MAX)) begin
                     nxt.retries = r1 + pekm_pkg::RETRY_W'(1);
                  end
                  if (nxt.retries <= n3_ff) begin
                     nxt.pending = 1'b1;
                  end
               end
            end
         end
         pekm_pkg::CMD_RESPONSE: begin
            nxt.recv_time = s1_now_ff;
            nxt.retries   = '0;
            nxt.error     = 1'b0;
         end
         pekm_pkg::CMD_SEND: begin
            if (cur.pending) begin
               send_flag     = 1'b1;
               nxt.send_time = s1_now_ff;
               nxt.pending   = 1'b0;
               nxt.sent      = cur.sent + pekm_pkg::COUNT_W'(1);
            end
         end
         default: ;  // unused command: state unchanged
      endcase
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic                          send_echo_ff;
   logic                          error_notify_ff;
   logic                          path_in_error_ff;
   logic                          echo_pending_ff;
   logic [pekm_pkg::RETRY_W-1:0]  retry_count_ff;
   logic [pekm_pkg::COUNT_W-1:0]  echo_sent_count_ff;
   logic [pekm_pkg::COUNT_W-1:0]  retransmit_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         // path outside the table reports all zeros
         send_echo_ff        <= s1_in_range_ff && send_flag;
         error_notify_ff     <= s1_in_range_ff && notify_flag;
         path_in_error_ff    <= s1_in_range_ff && err_flag;
         echo_pending_ff     <= s1_in_range_ff && nxt.pending;
         retry_count_ff      <= s1_in_range_ff ? nxt.retries : '0;
         echo_sent_count_ff  <= s1_in_range_ff ? nxt.sent : '0;
         retransmit_count_ff <= s1_in_range_ff ? nxt.rtx : '0;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.send_echo        = send_echo_ff;
   assign rsp_chan.error_notify     = error_notify_ff;
   assign rsp_chan.path_in_error    = path_in_error_ff;
   assign rsp_chan.echo_pending     = echo_pending_ff;
   assign rsp_chan.retry_count      = retry_count_ff;
   assign rsp_chan.echo_sent_count  = echo_sent_count_ff;
   assign rsp_chan.retransmit_count = retransmit_count_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A new error is always reported together with the error status.
   a_notify_in_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && error_notify_ff |-> path_in_error_ff && !send_echo_ff)
      else $error("error_notify without path_in_error");

   // A sent echo leaves nothing pending on that path.
   a_send_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && send_echo_ff |-> !echo_pending_ff)
      else $error("echo still pending after send");

   // A held stage-1 transaction keeps its address and command.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_addr_ff)
                                 && $stable(s1_cmd_ff))
      else $error("stage 1 changed while stalled");

   // Forwarding only from an in-range transaction that was written.
   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      req_fire && fwd_hit |-> wr_en)
      else $error("forward without matching write");

endmodule

// ----- tb/sv/path_echo_keepalive_monitor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_echo_keepalive_monitor_tb
// Self-checking bench for the path keepalive monitor. Commands are driven on
// the request channel with random idling. A status scoreboard keeps its own
// copy of the path table and predicts every response. Each phase programs a
// new set of timer and retry registers.
// ----------------------------------------------------------------------------
module path_echo_keepalive_monitor_tb;

   localparam int NUM_PATHS       = 64;
   localparam int NUM_SETTINGS    = 8;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 400;

   // Reserved command code, must leave the path untouched
   localparam logic [pekm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic                         send_echo;
      logic                         error_notify;
      logic                         path_in_error;
      logic                         echo_pending;
      logic [pekm_pkg::RETRY_W-1:0] retry_count;
      logic [pekm_pkg::COUNT_W-1:0] echo_sent_count;
      logic [pekm_pkg::COUNT_W-1:0] retransmit_count;
   } path_status_type;

   // -------------------------------------------------------------------------
   // Status scoreboard: shadow path table plus the queue of predicted status
   // -------------------------------------------------------------------------
   class keepalive_scoreboard;
      logic [pekm_pkg::T3_W-1:0]    t3_wait;
      logic [pekm_pkg::ECHO_W-1:0]  echo_period;
      logic [pekm_pkg::N3_W-1:0]    n3_limit;
      logic [pekm_pkg::NOW_W-1:0]   send_stamp [NUM_PATHS];
      logic [pekm_pkg::NOW_W-1:0]   recv_stamp [NUM_PATHS];
      logic [pekm_pkg::RETRY_W-1:0] retry_cnt  [NUM_PATHS];
      bit                           pending    [NUM_PATHS];
      bit                           in_error   [NUM_PATHS];
      logic [pekm_pkg::COUNT_W-1:0] sent_cnt   [NUM_PATHS];
      logic [pekm_pkg::COUNT_W-1:0] rexmit_cnt [NUM_PATHS];
      path_status_type              status_q[$];
      int                           fail_count;

      function new();
         t3_wait     = pekm_pkg::T3_RESET;
         echo_period = pekm_pkg::ECHO_RESET;
         n3_limit    = pekm_pkg::N3_RESET;
         fail_count  = 0;
         for (int i = 0; i < NUM_PATHS; i++) begin
            send_stamp[i] = '0;
            recv_stamp[i] = '0;
            retry_cnt[i]  = '0;
            pending[i]    = 1'b0;
            in_error[i]   = 1'b0;
            sent_cnt[i]   = '0;
            rexmit_cnt[i] = '0;
         end
      endfunction

      function void write_register(logic [pekm_pkg::CSR_IDX_W-1:0] idx,
                                   logic [pekm_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            pekm_pkg::CSR_T3:   t3_wait     = data[pekm_pkg::T3_W-1:0];
            pekm_pkg::CSR_ECHO: echo_period = data[pekm_pkg::ECHO_W-1:0];
            pekm_pkg::CSR_N3:   n3_limit    = data[pekm_pkg::N3_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_command(logic [pekm_pkg::CMD_W-1:0] op,
                                 logic [pekm_pkg::PATH_W-1:0] path,
                                 logic [pekm_pkg::NOW_W-1:0] stamp);
         path_status_type            st;
         logic [pekm_pkg::NOW_W-1:0] since_send;
         logic [pekm_pkg::NOW_W-1:0] gap;
         bit                         stale;
         st = '0;
         case (op)
            pekm_pkg::CMD_CHECK: begin
               since_send = stamp - send_stamp[path];
               gap        = send_stamp[path] - recv_stamp[path];
               if (retry_cnt[path] >= n3_limit && since_send >= t3_wait) begin
                  if (!in_error[path]) begin
                     in_error[path]  = 1'b1;
                     st.error_notify = 1'b1;
                  end
                  st.path_in_error = 1'b1;
               end else begin
                  // no answer since the last send: younger than half the time range
                  stale = gap != 0 && !gap[pekm_pkg::NOW_W-1];
                  if (stale && since_send >= t3_wait && retry_cnt[path] == 0) begin
                     retry_cnt[path]  = pekm_pkg::RETRY_W'(1);
                     pending[path]    = 1'b1;
                     rexmit_cnt[path] = rexmit_cnt[path] + pekm_pkg::COUNT_W'(1);
                  end
                  if ((retry_cnt[path] != 0 && since_send >= t3_wait) ||
                      (retry_cnt[path] == 0 && since_send >= echo_period)) begin
                     if (!pending[path] && retry_cnt[path] != 0 &&
                         retry_cnt[path] < pekm_pkg::RETRY_MAX)
                        retry_cnt[path] = retry_cnt[path] + pekm_pkg::RETRY_W'(1);
                     if (retry_cnt[path] <= n3_limit)
                        pending[path] = 1'b1;
                  end
               end
            end
            pekm_pkg::CMD_RESPONSE: begin
               recv_stamp[path] = stamp;
               retry_cnt[path]  = '0;
               in_error[path]   = 1'b0;
            end
            pekm_pkg::CMD_SEND: begin
               if (pending[path]) begin
                  st.send_echo     = 1'b1;
                  send_stamp[path] = stamp;
                  pending[path]    = 1'b0;
                  sent_cnt[path]   = sent_cnt[path] + pekm_pkg::COUNT_W'(1);
               end
            end
            default: ;
         endcase
         st.echo_pending     = pending[path];
         st.retry_count      = retry_cnt[path];
         st.echo_sent_count  = sent_cnt[path];
         st.retransmit_count = rexmit_cnt[path];
         status_q.push_back(st);
      endfunction

      function string describe(path_status_type s);
         return $sformatf({"send=%0b new_err=%0b in_err=%0b pend=%0b",
                           " retries=%0d sent=%0d rexmit=%0d"},
                          s.send_echo, s.error_notify, s.path_in_error, s.echo_pending,
                          s.retry_count, s.echo_sent_count, s.retransmit_count);
      endfunction

      function void check_result(path_status_type got);
         path_status_type want;
         string           diff;
         diff = "";
         if (status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("ERROR: %0t status with no command outstanding: %s",
                        $realtime, describe(got));
            return;
         end
         want = status_q.pop_front();
         if (got.send_echo        !== want.send_echo)        diff = {diff, " send_echo"};
         if (got.error_notify     !== want.error_notify)     diff = {diff, " error_notify"};
         if (got.path_in_error    !== want.path_in_error)    diff = {diff, " path_in_error"};
         if (got.echo_pending     !== want.echo_pending)     diff = {diff, " echo_pending"};
         if (got.retry_count      !== want.retry_count)      diff = {diff, " retry_count"};
         if (got.echo_sent_count  !== want.echo_sent_count)  diff = {diff, " echo_sent_count"};
         if (got.retransmit_count !== want.retransmit_count) diff = {diff, " retransmit_count"};
         if (diff != "") begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("ERROR: %0t status mismatch in%s", $realtime, diff);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction

      function int outstanding();
         return status_q.size();
      endfunction

      function int failures();
         return fail_count + status_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [pekm_pkg::CSR_IDX_W-1:0]  csr_index        = '0;
   logic [pekm_pkg::CSR_DATA_W-1:0] csr_write_data   = '0;

   always #10 clock = ~clock;

   pekm_req_if req_if ();
   pekm_rsp_if rsp_if ();

   path_echo_keepalive_monitor #(
      .NUM_PATHS (NUM_PATHS),
      .TIME_BITS (pekm_pkg::NOW_W)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   keepalive_scoreboard status_board;

   bit gaps_on         = 1'b1;  // random idling on both channels
   bit hold_armed      = 1'b0;  // asks the sink for one long receiver hold-off
   int cycle_count     = 0;
   int n_commands      = 0;
   int n_results       = 0;
   int n_echoes        = 0;
   int n_error_events  = 0;
   int n_error_reports = 0;

   // -------------------------------------------------------------------------
   // Request side. Called at a falling edge, returns at the falling edge after
   // the transaction is taken. valid stays up so a following call can keep the
   // channel busy back to back; whoever stops sending must drop it.
   // -------------------------------------------------------------------------
   task automatic drive_command(input logic [pekm_pkg::CMD_W-1:0] op,
                                input logic [pekm_pkg::PATH_W-1:0] path,
                                input logic [pekm_pkg::NOW_W-1:0] stamp);
      while (gaps_on && $urandom_range(0, 99) < 19) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= op;
      req_if.path_index <= path;
      req_if.now_ms     <= stamp;
      // ready is sampled at the edge, before any flop of the block updates
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      status_board.note_command(op, path, stamp);
      n_commands++;
      @(negedge clock);
   endtask

   // Registers are only written with no transaction in flight
   task automatic program_registers(input logic [pekm_pkg::CSR_DATA_W-1:0] t3_val,
                                    input logic [pekm_pkg::CSR_DATA_W-1:0] echo_val,
                                    input logic [pekm_pkg::CSR_DATA_W-1:0] n3_val);
      csr_write_enable <= 1'b1;
      csr_index        <= pekm_pkg::CSR_T3;
      csr_write_data   <= t3_val;
      status_board.write_register(pekm_pkg::CSR_T3, t3_val);
      @(negedge clock);
      csr_index        <= pekm_pkg::CSR_ECHO;
      csr_write_data   <= echo_val;
      status_board.write_register(pekm_pkg::CSR_ECHO, echo_val);
      @(negedge clock);
      csr_index        <= pekm_pkg::CSR_N3;
      csr_write_data   <= n3_val;
      status_board.write_register(pekm_pkg::CSR_N3, n3_val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (status_board.outstanding() != 0) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold-off, counted
   // here, so the block fills up and pushes back on the request channel.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int hold_left;
      bit hold_used;
      hold_left    = 0;
      hold_used    = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= !(gaps_on && $urandom_range(0, 99) < 19);
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      path_status_type observed;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         observed = {rsp_if.send_echo, rsp_if.error_notify, rsp_if.path_in_error,
                     rsp_if.echo_pending, rsp_if.retry_count, rsp_if.echo_sent_count,
                     rsp_if.retransmit_count};
         status_board.check_result(observed);
         n_results++;
         if (rsp_if.send_echo === 1'b1)     n_echoes++;
         if (rsp_if.error_notify === 1'b1)  n_error_events++;
         if (rsp_if.path_in_error === 1'b1) n_error_reports++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: no completion after %0d cycles, %0d status outstanding",
                  cycle_count, status_board.outstanding());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [pekm_pkg::NOW_W-1:0]      clock_ms;
      logic [pekm_pkg::NOW_W-1:0]      t;
      logic [pekm_pkg::CSR_DATA_W-1:0] t3_val;
      logic [pekm_pkg::CSR_DATA_W-1:0] echo_val;
      logic [pekm_pkg::CSR_DATA_W-1:0] n3_val;
      logic [pekm_pkg::PATH_W-1:0]     hot_base;
      logic [pekm_pkg::CMD_W-1:0]      op;
      int unsigned                     span_short;
      int unsigned                     span_long;
      int unsigned                     pick;
      bit                              near_wrap;

      req_if.valid      = 1'b0;
      req_if.cmd        = pekm_pkg::CMD_CHECK;
      req_if.path_index = '0;
      req_if.now_ms     = '0;
      status_board      = new();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, reset register values ----
      drive_command(pekm_pkg::CMD_CHECK, 6'd0, 32'h0);          // nothing elapsed
      drive_command(CMD_UNUSED, 6'd0, 32'hFFFF_FFFF);           // reserved command, top time
      drive_command(pekm_pkg::CMD_SEND, 6'd0, 32'd5);           // send slot, nothing pending
      drive_command(pekm_pkg::CMD_RESPONSE, 6'd1, 32'hFFFF_FFFF);
      drive_command(pekm_pkg::CMD_CHECK, 6'd1, 32'h0);          // receive time ahead of send
      drive_command(pekm_pkg::CMD_CHECK, 6'd2, 32'hFFFF_FFFF);  // routine echo due
      // unanswered echoes on the last path: retransmits build up to n3, then the
      // path goes into error once, and the next check just reports it
      t = 32'd60000;
      repeat (8) begin
         drive_command(pekm_pkg::CMD_CHECK, 6'd63, t);
         drive_command(pekm_pkg::CMD_SEND, 6'd63, t + 1);
         t = t + 3001;
      end
      drive_command(pekm_pkg::CMD_RESPONSE, 6'd63, t);          // clears retries and error
      drive_command(pekm_pkg::CMD_CHECK, 6'd63, t + 1);

      // ---- random phases, one register setting each ----
      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         drain_results();
         near_wrap = 1'b0;
         case (phase)
            0: begin t3_val = 22'd1; echo_val = 22'd1; n3_val = 22'd1; end
            // zero timers always expire; zero n3 makes every expired check an error
            1: begin t3_val = 22'd0; echo_val = 22'd0; n3_val = 22'd0; end
            // all-ones writes: only each register's own width is kept
            2: begin
               t3_val = 22'h3F_FFFF; echo_val = 22'h3F_FFFF; n3_val = 22'h3F_FFFF;
               near_wrap = 1'b1;
            end
            3: begin t3_val = 22'd20; echo_val = 22'd100; n3_val = 22'd15; end
            4: begin t3_val = 22'd7; echo_val = 22'd40; n3_val = 22'd3; end
            5: begin
               t3_val   = pekm_pkg::CSR_DATA_W'($urandom_range(50, 500));
               echo_val = pekm_pkg::CSR_DATA_W'($urandom_range(200, 3000));
               n3_val   = pekm_pkg::CSR_DATA_W'($urandom_range(1, 15));
            end
            6: begin
               t3_val = 22'd1000000; echo_val = 22'd4000000; n3_val = 22'd15;
               near_wrap = 1'b1;
            end
            default: begin t3_val = 22'd150; echo_val = 22'd900; n3_val = 22'h3F_FFF2; end
         endcase
         program_registers(t3_val, echo_val, n3_val);

         span_short = status_board.t3_wait + status_board.t3_wait / 2 + 2;
         span_long  = status_board.echo_period + status_board.echo_period / 4 + 2;
         hot_base   = pekm_pkg::PATH_W'($urandom_range(0, NUM_PATHS - 4));
         clock_ms   = near_wrap ? 32'hFFFF_FFFF - $urandom_range(0, 4 * span_long)
                                : $urandom();

         // one phase runs flat out, one starts with a long receiver stall
         gaps_on = (phase != 4);
         if (phase == 3) hold_armed = 1'b1;

         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 10) begin
               // noise: any command, any path, any time
               drive_command(pekm_pkg::CMD_W'($urandom_range(0, 3)),
                             pekm_pkg::PATH_W'($urandom_range(0, NUM_PATHS - 1)),
                             $urandom());
            end else begin
               // well-formed traffic on a few paths with time moving forward
               if ($urandom_range(0, 3) == 0) clock_ms = clock_ms + $urandom_range(0, span_long);
               else                           clock_ms = clock_ms + $urandom_range(0, span_short);
               pick = $urandom_range(0, 99);
               if (pick < 48)      op = pekm_pkg::CMD_CHECK;
               else if (pick < 86) op = pekm_pkg::CMD_SEND;
               else if (pick < 97) op = pekm_pkg::CMD_RESPONSE;
               else                op = CMD_UNUSED;
               drive_command(op, pekm_pkg::PATH_W'(hot_base + $urandom_range(0, 3)),
                             clock_ms);
            end
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d commands over %0d register settings, %0d status checked",
               n_commands, NUM_SETTINGS + 1, n_results);
      $display("Seen: %0d echo sends, %0d new path errors, %0d in-error reports",
               n_echoes, n_error_events, n_error_reports);
      if (status_board.failures() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("ERROR: %0d failures, %0d status never returned",
                  status_board.failures(), status_board.outstanding());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/pekm_pkg.sv
hw/rtl/pekm_req_if.sv
hw/rtl/pekm_rsp_if.sv
hw/rtl/path_echo_keepalive_monitor.sv
tb/sv/path_echo_keepalive_monitor_tb.sv
